FILE: sv/mdhcc_pkg.sv
// package for the median dead/hot channel counter
// holds payload structs, state codes and register indexes; no dependencies
`default_nettype none
package mdhcc_pkg;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_FRACTION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_MULTIPLIER = 1'b1;

   localparam logic [15:0] DEAD_FRACTION_RESET = 16'd3277;
   localparam logic [15:0] HOT_MULTIPLIER_RESET = 16'd1280;

   typedef struct packed {
      logic [31:0] hit_count;
      logic        present;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [7:0]  dead_total;
      logic [7:0]  hot_total;
      logic [32:0] median_times_two;
      logic [7:0]  total_channels;
      logic [7:0]  present_channels;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SELECT,
      ST_LIMIT,
      ST_THRESH,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

FILE: sv/mdhcc_store.sv
// count store: one write port, one read port with registered read data
// no dependencies
`default_nettype none
module mdhcc_store #(
   parameter int DEPTH = 128,
   parameter int AW = 7
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data
);
   logic [31:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: sv/median_dead_hot_channel_count_unit.sv
// median dead/hot channel counter: loads one count per transfer, then a bitwise
// radix select of both middle values takes 32 passes over the count store, a
// multiply step and a threshold pass; the result register holds until taken.
// one store read per cycle within each pass. synchronous reset clears control
// state and restores the register defaults; the store itself is not cleared
`default_nettype none
module median_dead_hot_channel_count_unit #(
   parameter int MAX_CHANNELS = 128
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire mdhcc_pkg::req_type                 req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output mdhcc_pkg::rsp_type                      rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [mdhcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [15:0]                        csr_wdata
);
   import mdhcc_pkg::*;

   localparam int AW = $clog2(MAX_CHANNELS);
   localparam int CW = $clog2(MAX_CHANNELS + 1);
   localparam logic [CW-1:0] MAX_N = CW'(MAX_CHANNELS);

   state_type state_ff, state_in;
   logic [15:0] dead_ratio_ff, hot_scale_ff;
   logic [CW-1:0] loaded_ff, loaded_in, present_ff, present_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic rv_ff, rl_ff;
   logic [31:0] bsel_ff, bsel_in, mask_ff, mask_in;
   logic [31:0] pre_lo_ff, pre_lo_in, pre_hi_ff, pre_hi_in;
   logic [CW-1:0] k_lo_ff, k_lo_in, k_hi_ff, k_hi_in;
   logic [CW-1:0] c_lo_ff, c_lo_in, c_hi_ff, c_hi_in;
   logic [32:0] m2_ff, m2_in;
   logic [48:0] dlim_ff, hlim_ff;
   logic [CW-1:0] dead_ff, dead_in, hot_ff, hot_in;
   rsp_type rsp_ff;

   logic accept, issuing, wr_en, pass_done, last_bit;
   logic [31:0] rd_data;
   logic inc_lo, inc_hi, is_dead, is_hot;
   logic [CW-1:0] tot_lo, tot_hi, n_new, p_new;

   assign accept = req_valid && req_ready;
   assign wr_en = accept && (loaded_ff < MAX_N);
   assign n_new = wr_en ? loaded_ff + 1'b1 : loaded_ff;
   assign p_new = (wr_en && req_data.present) ? present_ff + 1'b1 : present_ff;
   assign pass_done = rv_ff && rl_ff;
   assign last_bit = bsel_ff[0];

   mdhcc_store #(.DEPTH(MAX_CHANNELS), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data (req_data.hit_count),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_data.last && p_new != '0) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (pass_done && last_bit) begin
               state_in = ST_LIMIT;
            end
         end
         ST_LIMIT: state_in = ST_THRESH;
         ST_THRESH: begin
            if (pass_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      issuing = 1'b0;
      case (state_ff)
         ST_LOAD: req_ready = 1'b1;
         ST_SELECT, ST_THRESH: issuing = (issue_ff < loaded_ff);
         ST_LIMIT: ;
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      inc_lo = rv_ff && (((rd_data ^ pre_lo_ff) & mask_ff) == '0) && ((rd_data & bsel_ff) == '0);
      inc_hi = rv_ff && (((rd_data ^ pre_hi_ff) & mask_ff) == '0) && ((rd_data & bsel_ff) == '0);
      tot_lo = c_lo_ff + CW'(inc_lo);
      tot_hi = c_hi_ff + CW'(inc_hi);
      is_dead = rv_ff && ({rd_data, 17'd0} < dlim_ff);
      is_hot = rv_ff && ({17'd0, rd_data, 9'd0} > {9'd0, hlim_ff[48:9], 9'd0} ||
                        ({17'd0, rd_data, 9'd0} > hlim_ff));

      loaded_in = loaded_ff;
      present_in = present_ff;
      issue_in = issuing ? issue_ff + 1'b1 : issue_ff;
      bsel_in = bsel_ff;
      mask_in = mask_ff;
      pre_lo_in = pre_lo_ff;
      pre_hi_in = pre_hi_ff;
      k_lo_in = k_lo_ff;
      k_hi_in = k_hi_ff;
      c_lo_in = c_lo_ff;
      c_hi_in = c_hi_ff;
      m2_in = m2_ff;
      dead_in = dead_ff;
      hot_in = hot_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               loaded_in = n_new;
               present_in = p_new;
               if (req_data.last) begin
                  if (p_new == '0) begin
                     loaded_in = '0;
                     present_in = '0;
                  end
                  issue_in = '0;
                  bsel_in = 32'h8000_0000;
                  mask_in = '0;
                  pre_lo_in = '0;
                  pre_hi_in = '0;
                  k_lo_in = (n_new - 1'b1) >> 1;
                  k_hi_in = n_new >> 1;
                  c_lo_in = '0;
                  c_hi_in = '0;
               end
            end
         end
         ST_SELECT: begin
            c_lo_in = tot_lo;
            c_hi_in = tot_hi;
            if (pass_done) begin
               if (k_lo_ff >= tot_lo) begin
                  pre_lo_in = pre_lo_ff | bsel_ff;
                  k_lo_in = k_lo_ff - tot_lo;
               end
               if (k_hi_ff >= tot_hi) begin
                  pre_hi_in = pre_hi_ff | bsel_ff;
                  k_hi_in = k_hi_ff - tot_hi;
               end
               c_lo_in = '0;
               c_hi_in = '0;
               bsel_in = {1'b0, bsel_ff[31:1]};
               mask_in = {1'b1, mask_ff[31:1]};
               issue_in = '0;
            end
         end
         ST_LIMIT: begin
            m2_in = {1'b0, pre_lo_ff} + {1'b0, pre_hi_ff};
            issue_in = '0;
            dead_in = '0;
            hot_in = '0;
         end
         ST_THRESH: begin
            if (is_dead) dead_in = dead_ff + 1'b1;
            if (is_hot) hot_in = hot_ff + 1'b1;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               loaded_in = '0;
               present_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         loaded_ff <= '0;
         present_ff <= '0;
         issue_ff <= '0;
         rv_ff <= 1'b0;
         rl_ff <= 1'b0;
         dead_ratio_ff <= DEAD_FRACTION_RESET;
         hot_scale_ff <= HOT_MULTIPLIER_RESET;
      end else begin
         state_ff <= state_in;
         loaded_ff <= loaded_in;
         present_ff <= present_in;
         issue_ff <= issue_in;
         rv_ff <= issuing;
         rl_ff <= issuing && (issue_ff == loaded_ff - 1'b1);
         if (csr_we) begin
            case (csr_index)
               CSR_DEAD_FRACTION: dead_ratio_ff <= csr_wdata;
               CSR_HOT_MULTIPLIER: hot_scale_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      bsel_ff <= bsel_in;
      mask_ff <= mask_in;
      pre_lo_ff <= pre_lo_in;
      pre_hi_ff <= pre_hi_in;
      k_lo_ff <= k_lo_in;
      k_hi_ff <= k_hi_in;
      c_lo_ff <= c_lo_in;
      c_hi_ff <= c_hi_in;
      m2_ff <= m2_in;
      dead_ff <= dead_in;
      hot_ff <= hot_in;
      if (state_ff == ST_THRESH && state_in == ST_LIMIT) begin
         dlim_ff <= '0;
      end
      if (state_ff == ST_LIMIT) begin
         dlim_ff <= {33'd0, dead_ratio_ff} * {16'd0, m2_in};
         hlim_ff <= {33'd0, hot_scale_ff} * {16'd0, m2_in};
      end
      if (state_ff == ST_THRESH && pass_done) begin
         rsp_ff.dead_total <= 8'(dead_in);
         rsp_ff.hot_total <= 8'(hot_in);
         rsp_ff.median_times_two <= m2_ff;
         rsp_ff.total_channels <= 8'(loaded_ff);
         rsp_ff.present_channels <= 8'(present_ff);
      end
   end

   assign rsp_data = rsp_ff;

   a_no_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> present_ff != '0) else $error("result for a set with nothing present");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= MAX_N) else $error("store fill beyond depth");
   a_sides_apart: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("load and result overlap");
   a_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SELECT |-> $onehot(bsel_ff)) else $error("select bit lost");
endmodule
`default_nettype wire
